@@ hdl/ucct_pkg.sv @@
// Package: shared types and constants of the UDP client counter table.
`default_nettype none
package ucct_pkg;
	localparam int TableDepth = 64;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);

	localparam logic [1:0] ST_REPLY  = 2'd0;
	localparam logic [1:0] ST_DROP   = 2'd1;
	localparam logic [1:0] ST_CLOSED = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam logic [3:0] IP_V4     = 4'd4;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// classified job handed from front to back
	typedef struct packed {
		logic        pass;
		logic        close_req;
		logic [31:0] ip;
		logic [15:0] port;
	} job_t;
endpackage
`default_nettype wire

@@ hdl/ucct_front.sv @@
// Front end: input filter and a two-entry job queue toward the table engine.
`default_nettype none
module ucct_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic               action,
	input  wire logic [3:0]         ip_version,
	input  wire logic [7:0]         protocol,
	input  wire logic [3:0]         header_words,
	input  wire logic [15:0]        dest_port,
	input  wire logic [31:0]        client_ip,
	input  wire logic [15:0]        client_port,
	input  wire logic [15:0]        udp_length,
	input  wire logic [15:0]        received_length,
	input  wire logic [15:0]        udp_port,
	output logic                    full,
	output logic                    job_valid,
	output ucct_pkg::job_t          job,
	input  wire logic               job_pop
);
	import ucct_pkg::*;

	logic [16:0] hlen;
	logic [16:0] rlen;
	logic        pass;
	job_t        q_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;

	always_comb begin
		hlen = {11'd0, header_words, 2'b00};
		rlen = {1'b0, received_length};
		pass = (received_length >= 16'd20) && (ip_version == IP_V4) &&
			(protocol == PROTO_UDP) && (rlen >= hlen + 17'd8) &&
			(dest_port == udp_port) && (udp_length >= 16'd8) &&
			(rlen >= hlen + {1'b0, udp_length});
	end

	assign full      = cnt_q[1];
	assign job_valid = cnt_q != 2'd0;
	assign job       = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (take) begin
			q_q[wr_q] <= '{pass: pass, close_req: action, ip: client_ip, port: client_port};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (take) wr_q <= ~wr_q;
			if (job_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, take} - {1'b0, job_pop};
		end
	end
endmodule
`default_nettype wire

@@ hdl/ucct_back.sv @@
// Back end: table scan, append, remove and counter update.
`default_nettype none
module ucct_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   job_valid,
	input  wire ucct_pkg::job_t         job,
	output logic                        job_pop,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [31:0]                 message_count,
	output logic [31:0]                 reply_ip,
	output logic [15:0]                 reply_port,
	output logic [ucct_pkg::CntW-1:0]   clients_in_use
);
	import ucct_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_CMP = 3'd2,
		S_LAST = 3'd3, S_MOVE = 3'd4, S_INC = 3'd5;

	logic [31:0] addr_mem [TableDepth];
	logic [15:0] port_mem [TableDepth];
	logic [31:0] cnt_mem  [TableDepth];

	logic [2:0]      state_q;
	job_t            job_q;
	logic [CntW-1:0] used_q;
	logic [CntW-1:0] i_q;
	logic [IdxW-1:0] hit_q;
	logic [31:0]     rd_addr_q, rd_cnt_q;
	logic [15:0]     rd_port_q;
	logic            we;
	logic [IdxW-1:0] wa;
	logic [31:0]     wd_addr, wd_cnt;
	logic [15:0]     wd_port;
	logic [IdxW-1:0] ra;

	assign job_pop = (state_q == S_IDLE) && job_valid;

	// read address: scan index, or the last entry while a close is pending
	assign ra = i_q[IdxW-1:0];

	always_ff @(posedge clk) begin
		rd_addr_q <= addr_mem[ra];
		rd_port_q <= port_mem[ra];
		rd_cnt_q  <= cnt_mem[ra];
		if (we) begin
			addr_mem[wa] <= wd_addr;
			port_mem[wa] <= wd_port;
			cnt_mem[wa]  <= wd_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			used_q         <= '0;
			i_q            <= '0;
			hit_q          <= '0;
			we             <= 1'b0;
			wa             <= '0;
			wd_addr        <= '0;
			wd_port        <= '0;
			wd_cnt         <= '0;
			done           <= 1'b0;
			status         <= ST_REPLY;
			message_count  <= '0;
			reply_ip       <= '0;
			reply_port     <= '0;
			clients_in_use <= '0;
		end else begin
			we   <= 1'b0;
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (job_pop) begin
						if (!job.pass) begin
							done           <= 1'b1;
							status         <= ST_DROP;
							message_count  <= '0;
							reply_ip       <= '0;
							reply_port     <= '0;
							clients_in_use <= used_q;
						end else begin
							i_q     <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				// issue read of entry i
				S_SCAN: begin
					if (i_q == used_q) begin
						// not found
						done          <= 1'b1;
						message_count <= '0;
						reply_ip      <= job_q.ip;
						reply_port    <= job_q.port;
						state_q       <= S_IDLE;
						if (job_q.close_req) begin
							status         <= ST_CLOSED;
							clients_in_use <= used_q;
						end else if (used_q == CntW'(TableDepth)) begin
							status         <= ST_FULL;
							clients_in_use <= used_q;
						end else begin
							we             <= 1'b1;
							wa             <= used_q[IdxW-1:0];
							wd_addr        <= job_q.ip;
							wd_port        <= job_q.port;
							wd_cnt         <= 32'd1;
							used_q         <= used_q + 1'b1;
							status         <= ST_REPLY;
							message_count  <= 32'd1;
							clients_in_use <= used_q + 1'b1;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (rd_addr_q == job_q.ip && rd_port_q == job_q.port) begin
						hit_q <= i_q[IdxW-1:0];
						if (job_q.close_req) begin
							i_q     <= used_q - 1'b1;
							state_q <= S_LAST;
						end else begin
							we             <= 1'b1;
							wa             <= i_q[IdxW-1:0];
							wd_addr        <= rd_addr_q;
							wd_port        <= rd_port_q;
							wd_cnt         <= rd_cnt_q + 32'd1;
							done           <= 1'b1;
							status         <= ST_REPLY;
							message_count  <= rd_cnt_q + 32'd1;
							reply_ip       <= job_q.ip;
							reply_port     <= job_q.port;
							clients_in_use <= used_q;
							state_q        <= S_INC;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				// read of last entry issued (ra = i_q); wait for the registered read data
				S_LAST: state_q <= S_MOVE;
				S_MOVE: begin
					we             <= 1'b1;
					wa             <= hit_q;
					wd_addr        <= rd_addr_q;
					wd_port        <= rd_port_q;
					wd_cnt         <= rd_cnt_q;
					used_q         <= used_q - 1'b1;
					done           <= 1'b1;
					status         <= ST_CLOSED;
					message_count  <= '0;
					reply_ip       <= job_q.ip;
					reply_port     <= job_q.port;
					clients_in_use <= used_q - 1'b1;
					state_q        <= S_IDLE;
				end
				// let the write land before the next scan
				S_INC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/udp_client_counter_table.sv @@
// Top level: UDP client counter table, front filter plus table engine.
//
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// config    | udp_port_we          | udp_port_wdata
// packet in | start & !busy        | action .. received_length
// result    | done (one cycle)     | status, message_count, reply_ip/port, ...
//
// With the engine idle, a dropped packet is answered from S_IDLE, a counted
// hit from S_CMP, and a miss from S_SCAN once the scan passes the last used
// entry; a close of a found entry reads the last entry (S_LAST) and moves it
// into the freed slot (S_MOVE). Entries are read one at a time through the
// registered memory port; a counted hit passes S_INC before the next job.
// Two jobs can queue between filter and engine; busy rises when the queue is full.
// Reset empties the table (clients_in_use = 0) and sets the listen port to 1.
// The receiver cannot stall results.
`default_nettype none
module udp_client_counter_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        udp_port_we,
	input  wire logic [15:0] udp_port_wdata,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [3:0]  ip_version,
	input  wire logic [7:0]  protocol,
	input  wire logic [3:0]  header_words,
	input  wire logic [15:0] dest_port,
	input  wire logic [31:0] client_ip,
	input  wire logic [15:0] client_port,
	input  wire logic [15:0] udp_length,
	input  wire logic [15:0] received_length,
	output logic             done,
	output logic [1:0]       status,
	output logic [31:0]      message_count,
	output logic [31:0]      reply_ip,
	output logic [15:0]      reply_port,
	output logic [6:0]       clients_in_use
);
	import ucct_pkg::*;

	logic [15:0]     udp_port_q;
	logic            full, job_valid, job_pop;
	job_t            job;
	logic [CntW-1:0] used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) udp_port_q <= 16'd1;
		else if (udp_port_we) udp_port_q <= udp_port_wdata;
	end

	assign busy = full;

	ucct_front u_front (
		.clk, .arst_n, .take(start & ~full), .action, .ip_version, .protocol,
		.header_words, .dest_port, .client_ip, .client_port, .udp_length,
		.received_length, .udp_port(udp_port_q), .full, .job_valid, .job,
		.job_pop
	);

	ucct_back u_back (
		.clk, .arst_n, .job_valid, .job, .job_pop, .done, .status, .message_count,
		.reply_ip, .reply_port, .clients_in_use(used)
	);

	assign clients_in_use = 7'(used);
endmodule
`default_nettype wire
